/* src/phe_pkg.sv */
// shared types, constants and arctangent table for the heading error unit
package phe_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int VW            = 34;
	localparam int DW            = 36;

	localparam logic signed [VW-1:0] HALF_PI   = 34'sd1686629713;
	localparam logic signed [DW-1:0] PI_Q30    = 36'sd3373259426;
	localparam logic signed [DW-1:0] TWO_PI_Q30 = 36'sd6746518853;
	localparam logic signed [15:0]   HEAD_MAX  = 16'sd25736;

	// atan(2^-i) in Q30, truncated
	localparam logic [29:0] ATAN_TAB [32] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
		30'd67021686, 30'd33543515, 30'd16775850, 30'd8388437,
		30'd4194282, 30'd2097149, 30'd1048575, 30'd524287,
		30'd262143, 30'd131071, 30'd65535, 30'd32767,
		30'd16383, 30'd8191, 30'd4095, 30'd2047,
		30'd1023, 30'd511, 30'd255, 30'd127,
		30'd63, 30'd31, 30'd15, 30'd7,
		30'd3, 30'd1, 30'd0, 30'd0
	};

	// vector and angle accumulator handed along the rotation chain
	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
		logic                 zero;
	} phe_vec_t;

endpackage

/* src/phe_norm.sv */
// magnitude normalization and half-plane pre-rotation ahead of the rotation chain
module phe_norm (
	input  logic                               clk,
	input  logic signed [phe_pkg::VW-1:0]      vx,
	input  logic signed [phe_pkg::VW-1:0]      vy,
	output phe_pkg::phe_vec_t                  vout_s4
);
	import phe_pkg::*;

	logic [VW-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic          negx_s1, negy_s1, negx_s2, negy_s2, negx_s3, negy_s3;
	logic          zero_s2, zero_s3;
	logic [5:0]    msb_s2;
	logic [VW-1:0] orv;
	logic [5:0]    msb_c;
	logic [VW-1:0] sx_c, sy_c;
	logic signed [VW-1:0] cx_c, cy_c;
	phe_vec_t      v_c;

	// stage 1: magnitudes and signs
	always_ff @(posedge clk) begin
		ax_s1   <= vx[VW-1] ? VW'(-vx) : VW'(vx);
		ay_s1   <= vy[VW-1] ? VW'(-vy) : VW'(vy);
		negx_s1 <= vx[VW-1];
		negy_s1 <= vy[VW-1];
	end

	// leading one position of the larger magnitude
	assign orv = ax_s1 | ay_s1;
	always_comb begin
		msb_c = '0;
		for (int i = 0; i < VW; i++) begin
			if (orv[i]) msb_c = 6'(i);
		end
	end

	// stage 2: shift position
	always_ff @(posedge clk) begin
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		negx_s2 <= negx_s1;
		negy_s2 <= negy_s1;
		msb_s2  <= msb_c;
		zero_s2 <= (orv == '0);
	end

	// bring the larger magnitude into [2^29, 2^30)
	always_comb begin
		if (msb_s2 >= 6'd29) begin
			sx_c = ax_s2 >> (msb_s2 - 6'd29);
			sy_c = ay_s2 >> (msb_s2 - 6'd29);
		end else begin
			sx_c = ax_s2 << (6'd29 - msb_s2);
			sy_c = ay_s2 << (6'd29 - msb_s2);
		end
	end

	// stage 3: scaled magnitudes
	always_ff @(posedge clk) begin
		ax_s3   <= sx_c;
		ay_s3   <= sy_c;
		negx_s3 <= negx_s2;
		negy_s3 <= negy_s2;
		zero_s3 <= zero_s2;
	end

	// signs back, then turn left half-plane vectors by a quarter turn
	always_comb begin
		cx_c = negx_s3 ? -$signed(ax_s3) : $signed(ax_s3);
		cy_c = negy_s3 ? -$signed(ay_s3) : $signed(ay_s3);
		v_c.zero = zero_s3;
		if (cx_c < 0) begin
			if (cy_c >= 0) begin
				v_c.x = cy_c;
				v_c.y = -cx_c;
				v_c.z = HALF_PI;
			end else begin
				v_c.x = -cy_c;
				v_c.y = cx_c;
				v_c.z = -HALF_PI;
			end
		end else begin
			v_c.x = cx_c;
			v_c.y = cy_c;
			v_c.z = '0;
		end
	end

	// stage 4: vector into the chain
	always_ff @(posedge clk) begin
		vout_s4 <= v_c;
	end

endmodule

/* src/phe_cell.sv */
// one vectoring rotation step of the arctangent chain
module phe_cell (
	input  logic              clk,
	input  logic [4:0]        stage_idx,
	input  phe_pkg::phe_vec_t vin,
	output phe_pkg::phe_vec_t vout_s1
);
	import phe_pkg::*;

	logic signed [VW-1:0] sx, sy, ang;
	phe_vec_t             v_c;

	// rotate toward the x axis and track the angle
	always_comb begin
		sx  = vin.x >>> stage_idx;
		sy  = vin.y >>> stage_idx;
		ang = $signed({{(VW-30){1'b0}}, ATAN_TAB[stage_idx]});
		v_c.zero = vin.zero;
		if (vin.y >= 0) begin
			v_c.x = vin.x + sy;
			v_c.y = vin.y - sx;
			v_c.z = vin.z + ang;
		end else begin
			v_c.x = vin.x - sy;
			v_c.y = vin.y + sx;
			v_c.z = vin.z - ang;
		end
	end

	always_ff @(posedge clk) begin
		vout_s1 <= v_c;
	end

endmodule

/* src/pursuit_heading_error_unit.sv */
// heading error and reach flag unit: top level
//
// usage: drive the position and quaternion ports and raise start for one
// cycle per item; busy is held low, so an item is taken every cycle.
// each item gives one result: heading_error and reached appear for exactly
// one cycle with done high; results leave in start order. throughput is one
// item per cycle: two rows of rotation cells, one for the target bearing and
// one for the own yaw, each pass a vector to the next cell every cycle; an
// item passes through the front multipliers, a four-stage normalizer, the
// cell rows and a four-stage wrap and rounding tail.
// the reach radius is written through cfg_valid/cfg_ready (ready is always
// high) and must only change while no item is in flight.
// reset clears the in-flight marks and sets the radius to 1.0 m; the
// receiver cannot stall, so done is never held back.
module pursuit_heading_error_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  target_x,
	input  logic signed [31:0]  target_y,
	input  logic signed [31:0]  own_x,
	input  logic signed [31:0]  own_y,
	input  logic signed [15:0]  quat_w,
	input  logic signed [15:0]  quat_x,
	input  logic signed [15:0]  quat_y,
	input  logic signed [15:0]  quat_z,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [30:0]         cfg_data,
	output logic                done,
	output logic signed [15:0]  heading_error,
	output logic                reached
);
	import phe_pkg::*;

	localparam int LAT = CORDIC_STAGES + 10;

	logic [30:0]          radius_q;
	logic [LAT-1:0]       vld_q;

	logic signed [VW-1:0] dx_s1, dy_s1, dx_s2, dy_s2, siny_s2, cosy_s2;
	logic signed [31:0]   pwz_s1, pxy_s1, pyy_s1, pzz_s1;
	logic [VW-1:0]        adx_s2, ady_s2;
	logic                 far_s2, far_s3;
	logic [61:0]          dx2_s3, dy2_s3, rr_s3;
	logic                 reach_dly [LAT-3];

	phe_vec_t             bvec [CORDIC_STAGES+1];
	phe_vec_t             yvec [CORDIC_STAGES+1];

	logic signed [DW-1:0] d_s1, d_s2, d_s3, t_c;
	logic signed [18:0]   h_c;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// reach radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 31'd65536;
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= cfg_data;
		end
	end

	// in-flight marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end
	assign done = vld_q[LAT-1];

	// front stage 1: offsets and quaternion products
	always_ff @(posedge clk) begin
		dx_s1  <= VW'(target_x) - VW'(own_x);
		dy_s1  <= VW'(target_y) - VW'(own_y);
		pwz_s1 <= quat_w * quat_z;
		pxy_s1 <= quat_x * quat_y;
		pyy_s1 <= quat_y * quat_y;
		pzz_s1 <= quat_z * quat_z;
	end

	// front stage 2: yaw vector and offset magnitudes
	always_ff @(posedge clk) begin
		dx_s2   <= dx_s1;
		dy_s2   <= dy_s1;
		siny_s2 <= (VW'(pwz_s1) + VW'(pxy_s1)) <<< 1;
		cosy_s2 <= (VW'(1) <<< 28) - ((VW'(pyy_s1) + VW'(pzz_s1)) <<< 1);
		adx_s2  <= dx_s1[VW-1] ? VW'(-dx_s1) : VW'(dx_s1);
		ady_s2  <= dy_s1[VW-1] ? VW'(-dy_s1) : VW'(dy_s1);
	end

	assign far_s2 = (adx_s2[VW-1:31] != '0) || (ady_s2[VW-1:31] != '0);

	// reach squares
	always_ff @(posedge clk) begin
		far_s3 <= far_s2;
		dx2_s3 <= adx_s2[30:0] * adx_s2[30:0];
		dy2_s3 <= ady_s2[30:0] * ady_s2[30:0];
		rr_s3  <= radius_q * radius_q;
	end

	// reach compare, then delay to line up with the angle
	always_ff @(posedge clk) begin
		reach_dly[0] <= !far_s3 && ((63'(dx2_s3) + 63'(dy2_s3)) < 63'(rr_s3));
		for (int j = 1; j < LAT-3; j++) begin
			reach_dly[j] <= reach_dly[j-1];
		end
	end

	// normalizers for bearing and yaw
	phe_norm u_norm_b (.clk(clk), .vx(dx_s2),   .vy(dy_s2),   .vout_s4(bvec[0]));
	phe_norm u_norm_y (.clk(clk), .vx(cosy_s2), .vy(siny_s2), .vout_s4(yvec[0]));

	// rows of rotation cells
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		phe_cell u_cell_b (
			.clk(clk), .stage_idx(5'(g)), .vin(bvec[g]), .vout_s1(bvec[g+1])
		);
		phe_cell u_cell_y (
			.clk(clk), .stage_idx(5'(g)), .vin(yvec[g]), .vout_s1(yvec[g+1])
		);
	end

	// tail: difference with zero-vector angles forced to zero
	always_ff @(posedge clk) begin
		d_s1 <= (bvec[CORDIC_STAGES].zero ? DW'(0) : DW'(bvec[CORDIC_STAGES].z))
			- (yvec[CORDIC_STAGES].zero ? DW'(0) : DW'(yvec[CORDIC_STAGES].z));
	end

	// wrap once into [-pi, pi]
	always_ff @(posedge clk) begin
		d_s2 <= (d_s1 > PI_Q30) ? d_s1 - TWO_PI_Q30 : d_s1;
	end
	always_ff @(posedge clk) begin
		d_s3 <= (d_s2 < -PI_Q30) ? d_s2 + TWO_PI_Q30 : d_s2;
	end

	// round to Q3.13 and saturate
	assign t_c = d_s3 + (DW'(1) <<< 16);
	assign h_c = t_c[DW-1:17];

	always_ff @(posedge clk) begin
		if (h_c > 19'(HEAD_MAX)) begin
			heading_error <= HEAD_MAX;
		end else if (h_c < -19'(HEAD_MAX)) begin
			heading_error <= -HEAD_MAX;
		end else begin
			heading_error <= h_c[15:0];
		end
	end
	assign reached = reach_dly[LAT-4];

endmodule
